### rtl/cpav_pkg.sv
`default_nettype none
package cpav_pkg;

    // pipeline depths
    localparam int SQ_STEPS  = 34;
    localparam int DIV_STEPS = 25;

    // 1.001 in Q1.30
    localparam logic [30:0] SCALE_Q30 = 31'd1074815566;

    // register reset values
    localparam logic [23:0] DESIRED_RST = 24'd72090;
    localparam logic [23:0] MARGIN_RST  = 24'd3277;
    localparam logic [23:0] HEIGHT_RST  = 24'd13107;

    typedef enum logic [1:0] {
        REG_DESIRED = 2'd0,
        REG_MARGIN  = 2'd1,
        REG_HEIGHT  = 2'd2
    } t_reg_idx;

    // side data traveling with the root pipeline
    typedef struct packed {
        logic             ok;
        logic [2:0][31:0] owner;
        logic [2:0][32:0] mag;
        logic [2:0]       neg;
    } t_side;

    // side data traveling with the divider pipeline
    typedef struct packed {
        logic             ok;
        logic [2:0][31:0] owner;
        logic [2:0]       neg;
    } t_tail;

    // saturate to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/cpav_in_if.sv
`default_nettype none
interface cpav_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] owner_x;
    logic signed [31:0] owner_y;
    logic signed [31:0] owner_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic               target_present;

    modport source (
        output valid, owner_x, owner_y, owner_z, target_x, target_y, target_z,
               target_present,
        input  ready
    );
    modport sink (
        input  valid, owner_x, owner_y, owner_z, target_x, target_y, target_z,
               target_present,
        output ready
    );
endinterface
`default_nettype wire

### rtl/cpav_out_if.sv
`default_nettype none
interface cpav_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               updated;

    modport source (
        output valid, pos_x, pos_y, pos_z, updated,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, updated,
        output ready
    );
endinterface
`default_nettype wire

### rtl/cpav_sqrt.sv
`default_nettype none
module cpav_sqrt (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_v,
    input  wire logic [65:0]    i_rad,
    input  cpav_pkg::t_side     i_side,
    output logic                o_v,
    output logic [33:0]         o_root,
    output cpav_pkg::t_side     o_side
);
    import cpav_pkg::*;

    logic  [SQ_STEPS-1:0]        r_v;
    logic  [SQ_STEPS-1:0][67:0]  r_rad;
    logic  [SQ_STEPS-1:0][34:0]  r_rem;
    logic  [SQ_STEPS-1:0][33:0]  r_root;
    t_side                       r_side [SQ_STEPS];

    // stage inputs: stage 0 from the ports, others from the previous stage
    logic  [SQ_STEPS-1:0]        s_v;
    logic  [SQ_STEPS-1:0][67:0]  s_rad;
    logic  [SQ_STEPS-1:0][34:0]  s_rem;
    logic  [SQ_STEPS-1:0][33:0]  s_root;
    t_side                       s_side [SQ_STEPS];

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++) begin : g_stage
            logic [36:0] w_acc;
            logic [36:0] w_trial;
            logic        w_take;
            logic [34:0] n_rem;
            logic [33:0] n_root;

            if (k == 0) begin : g_first
                assign s_v[k]    = i_v;
                assign s_rad[k]  = {2'b00, i_rad};
                assign s_rem[k]  = '0;
                assign s_root[k] = '0;
                assign s_side[k] = i_side;
            end else begin : g_next
                assign s_v[k]    = r_v[k-1];
                assign s_rad[k]  = r_rad[k-1];
                assign s_rem[k]  = r_rem[k-1];
                assign s_root[k] = r_root[k-1];
                assign s_side[k] = r_side[k-1];
            end

            // one result bit: bring down two radicand bits, try 4r+1
            always_comb begin
                w_acc   = {s_rem[k], s_rad[k][67:66]};
                w_trial = {1'b0, s_root[k], 2'b01};
                w_take  = (w_acc >= w_trial);
                n_rem   = w_take ? 35'(w_acc - w_trial) : w_acc[34:0];
                n_root  = {s_root[k][32:0], w_take};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= s_v[k];
                end
                if (i_en) begin
                    r_rad[k]  <= {s_rad[k][65:0], 2'b00};
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_side[k] <= s_side[k];
                end
            end
        end
    endgenerate

    assign o_v    = r_v[SQ_STEPS-1];
    assign o_root = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule
`default_nettype wire

### rtl/cpav_div.sv
`default_nettype none
module cpav_div (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [57:0] i_num,
    input  wire logic [33:0] i_den,
    output logic      [24:0] o_quo
);
    import cpav_pkg::*;

    logic [DIV_STEPS-1:0][24:0] r_low;
    logic [DIV_STEPS-1:0][33:0] r_rem;
    logic [DIV_STEPS-1:0][33:0] r_den;
    logic [DIV_STEPS-1:0][24:0] r_quo;

    logic [DIV_STEPS-1:0][24:0] s_low;
    logic [DIV_STEPS-1:0][33:0] s_rem;
    logic [DIV_STEPS-1:0][33:0] s_den;
    logic [DIV_STEPS-1:0][24:0] s_quo;

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_stage
            logic [34:0] w_acc;
            logic        w_take;

            if (k == 0) begin : g_first
                assign s_low[k] = i_num[24:0];
                assign s_rem[k] = {1'b0, i_num[57:25]};
                assign s_den[k] = i_den;
                assign s_quo[k] = '0;
            end else begin : g_next
                assign s_low[k] = r_low[k-1];
                assign s_rem[k] = r_rem[k-1];
                assign s_den[k] = r_den[k-1];
                assign s_quo[k] = r_quo[k-1];
            end

            // restoring step: one quotient bit
            always_comb begin
                w_acc  = {s_rem[k], s_low[k][24]};
                w_take = (w_acc >= {1'b0, s_den[k]});
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_low[k] <= {s_low[k][23:0], 1'b0};
                    r_rem[k] <= w_take ? 34'(w_acc - {1'b0, s_den[k]}) : w_acc[33:0];
                    r_den[k] <= s_den[k];
                    r_quo[k] <= {s_quo[k][23:0], w_take};
                end
            end
        end
    endgenerate

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule
`default_nettype wire

### rtl/clamped_point_along_vector.sv
`default_nettype none
// Places a point on the line from owner toward target, at travel
// min(desired, max(length - margin, 0)) * 1.001, plus the height offset on y,
// all in signed Q16.16 with saturated results. One request is taken every
// cycle while no result is held; each result passes through the registers
// for the difference, magnitude, square and sum, the bit-per-stage square
// root, the travel clamp, scaling and numerators, the three bit-per-stage
// dividers and the output register. A held result stalls the whole
// pipeline; nothing is dropped. Configuration writes take effect at once
// and are meant for an idle block.
module clamped_point_along_vector (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpav_in_if.sink    i_req,
    cpav_out_if.source o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);
    import cpav_pkg::*;

    logic        en;
    logic [23:0] r_desired;
    logic [23:0] r_margin;
    logic [23:0] r_height;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desired <= DESIRED_RST;
            r_margin  <= MARGIN_RST;
            r_height  <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DESIRED: r_desired <= i_cfg_data;
                REG_MARGIN:  r_margin  <= i_cfg_data;
                REG_HEIGHT:  r_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance
    assign en          = !o_res.valid || o_res.ready;
    assign i_req.ready = en;

    // stage a: differences
    logic                    r_a_v;
    logic                    r_a_pres;
    logic [2:0][31:0]        r_a_own;
    logic [2:0][32:0]        r_a_d;
    // stage b: magnitudes
    logic                    r_b_v;
    logic                    r_b_pres;
    logic [2:0][31:0]        r_b_own;
    logic [2:0][32:0]        r_b_mag;
    logic [2:0]              r_b_neg;
    // stage c: squares
    logic                    r_c_v;
    logic                    r_c_pres;
    logic [2:0][31:0]        r_c_own;
    logic [2:0][32:0]        r_c_mag;
    logic [2:0]              r_c_neg;
    logic [2:0][65:0]        r_c_sq;
    // stage d: sum
    logic                    r_d_v;
    logic [65:0]             r_d_sum;
    t_side                   r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_req.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
        end
        if (en) begin
            r_a_pres   <= i_req.target_present;
            r_a_own[0] <= i_req.owner_x;
            r_a_own[1] <= i_req.owner_y;
            r_a_own[2] <= i_req.owner_z;
            r_a_d[0]   <= {i_req.target_x[31], i_req.target_x}
                        - {i_req.owner_x[31], i_req.owner_x};
            r_a_d[1]   <= {i_req.target_y[31], i_req.target_y}
                        - {i_req.owner_y[31], i_req.owner_y};
            r_a_d[2]   <= {i_req.target_z[31], i_req.target_z}
                        - {i_req.owner_z[31], i_req.owner_z};

            r_b_pres <= r_a_pres;
            r_b_own  <= r_a_own;
            for (int i = 0; i < 3; i++) begin
                r_b_neg[i] <= r_a_d[i][32];
                r_b_mag[i] <= r_a_d[i][32] ? 33'(-r_a_d[i]) : r_a_d[i];
            end

            r_c_pres <= r_b_pres;
            r_c_own  <= r_b_own;
            r_c_mag  <= r_b_mag;
            r_c_neg  <= r_b_neg;
            for (int i = 0; i < 3; i++) begin
                r_c_sq[i] <= 66'(r_b_mag[i]) * 66'(r_b_mag[i]);
            end

            r_d_sum        <= r_c_sq[0] + r_c_sq[1] + r_c_sq[2];
            r_d_side.ok    <= r_c_pres && (r_c_mag != '0);
            r_d_side.owner <= r_c_own;
            r_d_side.mag   <= r_c_mag;
            r_d_side.neg   <= r_c_neg;
        end
    end

    // square root pipeline
    logic        sq_v;
    logic [33:0] sq_root;
    t_side       sq_side;

    cpav_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (r_d_v),
        .i_rad   (r_d_sum),
        .i_side  (r_d_side),
        .o_v     (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage e: clamp travel
    logic        r_e_v;
    logic [33:0] r_e_dist;
    logic [23:0] r_e_t;
    t_side       r_e_side;
    // stage f: scale product
    logic        r_f_v;
    logic [33:0] r_f_dist;
    logic [54:0] r_f_prod;
    t_side       r_f_side;
    // stage g: rounded scaled travel
    logic        r_g_v;
    logic [33:0] r_g_dist;
    logic [24:0] r_g_ts;
    t_side       r_g_side;
    // stage h: numerators
    logic             r_h_v;
    logic [33:0]      r_h_dist;
    logic [2:0][57:0] r_h_num;
    t_tail            r_h_tail;

    logic [33:0] e_upper;
    logic [55:0] g_sum;

    always_comb begin
        e_upper = (sq_root > {10'd0, r_margin}) ? 34'(sq_root - {10'd0, r_margin}) : '0;
        g_sum   = {1'b0, r_f_prod} + 56'(1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
            r_h_v <= 1'b0;
        end else if (en) begin
            r_e_v <= sq_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
            r_h_v <= r_g_v;
        end
        if (en) begin
            r_e_dist <= sq_root;
            r_e_side <= sq_side;
            r_e_t    <= ({10'd0, r_desired} < e_upper) ? r_desired : e_upper[23:0];

            r_f_dist <= r_e_dist;
            r_f_side <= r_e_side;
            r_f_prod <= 55'(r_e_t) * 55'(SCALE_Q30);

            r_g_dist <= r_f_dist;
            r_g_side <= r_f_side;
            r_g_ts   <= g_sum[54:30];

            r_h_dist       <= r_g_dist;
            r_h_tail.ok    <= r_g_side.ok;
            r_h_tail.owner <= r_g_side.owner;
            r_h_tail.neg   <= r_g_side.neg;
            for (int i = 0; i < 3; i++) begin
                r_h_num[i] <= 58'(r_g_side.mag[i]) * 58'(r_g_ts)
                            + {25'd0, r_g_dist[33:1]};
            end
        end
    end

    // dividers, one per axis
    logic [2:0][24:0] quo;

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            cpav_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_h_num[a]),
                .i_den (r_h_dist),
                .o_quo (quo[a])
            );
        end
    endgenerate

    // side line alongside the dividers
    logic [DIV_STEPS-1:0] r_tl_v;
    t_tail                r_tl [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl_v <= '0;
        end else if (en) begin
            r_tl_v <= {r_tl_v[DIV_STEPS-2:0], r_h_v};
        end
        if (en) begin
            r_tl[0] <= r_h_tail;
            for (int i = 1; i < DIV_STEPS; i++) begin
                r_tl[i] <= r_tl[i-1];
            end
        end
    end

    // final sums and saturation
    t_tail                   fin;
    logic signed [2:0][34:0] p;

    always_comb begin
        fin = r_tl[DIV_STEPS-1];
        for (int i = 0; i < 3; i++) begin
            p[i] = 35'($signed(fin.owner[i]))
                 + (fin.neg[i] ? -35'($signed({1'b0, quo[i]}))
                               :  35'($signed({1'b0, quo[i]})));
        end
        p[1] = p[1] + 35'($signed(r_height));
    end

    logic r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_tl_v[DIV_STEPS-1];
        end
        if (en) begin
            o_res.updated <= fin.ok;
            o_res.pos_x   <= fin.ok ? sat32(p[0]) : '0;
            o_res.pos_y   <= fin.ok ? sat32(p[1]) : '0;
            o_res.pos_z   <= fin.ok ? sat32(p[2]) : '0;
        end
    end

    assign o_res.valid = r_out_v;

    // a held result stalls the input side
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_req.ready)
        else $error("input taken while result held");

    // no placement means a zero position
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.updated) |->
            (o_res.pos_x == 0 && o_res.pos_y == 0 && o_res.pos_z == 0))
        else $error("nonzero position without placement");

    // travel never exceeds the desired distance
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_v |-> (r_e_t <= r_desired))
        else $error("travel above desired distance");

endmodule
`default_nettype wire
